FILE: hw/rtl/tpbf_pkg.sv
// ----------------------------------------------------------------------------
// tpbf_pkg: shared types and constants for the token prefix blacklist filter
// Prefix table, token phase and back-end state encodings, and the command
// record passed from the classifier to the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package tpbf_pkg;

  // Prefix table geometry
  localparam int PATTERN_COUNT   = 9;
  localparam int MAX_PATTERN_LEN = 28;
  localparam int LEN_W           = $clog2(MAX_PATTERN_LEN + 1);
  localparam int IDX_W           = $clog2(MAX_PATTERN_LEN);

  // Command queue depth default
  localparam int CMD_FIFO_DEPTH  = 4;

  // Configuration port
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;
  localparam logic REG_FILTER_ENABLE = 1'b0;   // register index bit

  // Special bytes
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  typedef logic [LEN_W-1:0]         len_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [PATTERN_COUNT-1:0] mask_t;

  localparam mask_t ALL_PATTERNS = '1;

  // Patterns, right-justified: byte 0 of a pattern sits highest
  localparam logic [MAX_PATTERN_LEN*8-1:0] PAT_TEXT [PATTERN_COUNT] = '{
    {"stack_depot", "_disable"},
    {"cgroup", "_disable"},
    {"loop.max", "_part"},
    {"BOOT", "_IMAGE"},
    {"syscall", "_hardening"},
    {"button.lid", "_init_state"},
    "ROOT=",
    "SRC=",
    {"android", "boot.bootctrl", "_bootcfg"}
  };

  localparam int PAT_LEN [PATTERN_COUNT] = '{19, 14, 13, 10, 17, 21, 5, 4, 28};

  // Token phase
  typedef enum logic [1:0] {
    PH_BETWEEN,
    PH_BUFFER,
    PH_PASS,
    PH_DROP
  } phase_t;

  // Emitter state
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEP,
    BK_READ,
    BK_BUF,
    BK_TAIL
  } back_state_t;

  // One output run: optional separator, buffered bytes, optional tail byte
  typedef struct packed {
    logic       has_sep;
    len_t       flush_len;
    logic       has_tail;
    logic [7:0] tail_char;
  } cmd_t;

  // Token buffer write port
  typedef struct packed {
    logic       en;
    idx_t       addr;
    logic [7:0] data;
  } buf_wr_t;

  // Byte of pattern i at position pos (zero beyond its end)
  function automatic logic [7:0] pat_char(input int i, input idx_t pos);
    logic [7:0] ch;
    int         sh;
    sh = PAT_LEN[i] - 1 - int'(pos);
    if (sh < 0) begin
      ch = 8'h00;
    end else begin
      ch = PAT_TEXT[i][sh*8 +: 8];
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tpbf_ram.sv
// ----------------------------------------------------------------------------
// tpbf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tpbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 28
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tpbf_front.sv
// ----------------------------------------------------------------------------
// tpbf_front: input classifier
// Tracks token phase and prefix candidates, writes buffered token bytes and
// issues one output command per transaction that produces bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module tpbf_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             filter_enable,
  input  wire logic             in_valid,
  input  wire logic [7:0]       in_char,
  input  wire logic             in_eol,
  output      logic             in_stall,
  output      logic             cmd_push,
  output      tpbf_pkg::cmd_t    cmd,
  input  wire logic             cmd_full,
  input  wire logic             flush_done,
  output      tpbf_pkg::buf_wr_t buf_wr,
  output      logic             flush_pend
);
  import tpbf_pkg::*;

  len_t   len_r,   len_nxt;
  mask_t  mask_r,  mask_nxt;
  phase_t phase_r, phase_nxt;
  logic   first_r, first_nxt;
  logic   pend_r,  pend_nxt;

  logic   accept;
  len_t   len_e;
  mask_t  mask_e;
  phase_t ph_e;
  idx_t   pos;
  mask_t  keep;
  logic   hit;
  logic   do_flush;
  len_t   flush_len;
  logic   has_tail;
  logic [7:0] tail_char;

  // no new transaction while a flush still reads the buffer
  assign in_stall   = pend_r || cmd_full;
  assign accept     = in_valid && !in_stall;
  assign flush_pend = pend_r;

  // state as seen by a non-space byte (a new token starts from scratch)
  always_comb begin
    len_e  = (phase_r == PH_BETWEEN) ? '0 : len_r;
    mask_e = (phase_r == PH_BETWEEN) ? ALL_PATTERNS : mask_r;
    ph_e   = (phase_r == PH_BETWEEN) ? PH_BUFFER : phase_r;
    pos    = len_e[IDX_W-1:0];
  end

  // per-pattern compare of the incoming byte
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < PATTERN_COUNT; i++) begin
      keep[i] = mask_e[i] && (len_e < LEN_W'(PAT_LEN[i])) && (pat_char(i, pos) == in_char);
      if (keep[i] && (len_e + LEN_W'(1) == LEN_W'(PAT_LEN[i]))) begin
        hit = 1'b1;
      end
    end
  end

  // transaction classification and next state
  always_comb begin
    len_nxt     = len_r;
    mask_nxt    = mask_r;
    phase_nxt   = phase_r;
    first_nxt   = first_r;
    do_flush    = 1'b0;
    flush_len   = len_r;
    has_tail    = 1'b0;
    tail_char   = in_char;
    buf_wr.en   = 1'b0;
    buf_wr.addr = pos;
    buf_wr.data = in_char;

    if (accept) begin
      if (in_eol) begin
        do_flush  = filter_enable && (phase_r == PH_BUFFER);
        has_tail  = 1'b1;
        tail_char = CHAR_NEWLINE;
        len_nxt   = '0;
        mask_nxt  = ALL_PATTERNS;
        phase_nxt = PH_BETWEEN;
        first_nxt = 1'b1;
      end else if (!filter_enable) begin
        has_tail = 1'b1;
      end else if (in_char == CHAR_SPACE) begin
        do_flush  = (phase_r == PH_BUFFER);
        phase_nxt = PH_BETWEEN;
        if (do_flush) begin
          first_nxt = 1'b0;
        end
      end else begin
        len_nxt   = len_e;
        mask_nxt  = mask_e;
        phase_nxt = ph_e;
        case (ph_e)
          PH_PASS: begin
            has_tail = 1'b1;
          end
          PH_DROP: begin
          end
          default: begin
            if (len_e >= LEN_W'(MAX_PATTERN_LEN)) begin
              // full buffer: release it, byte follows
              do_flush  = 1'b1;
              flush_len = len_e;
              has_tail  = 1'b1;
              phase_nxt = PH_PASS;
              first_nxt = 1'b0;
            end else begin
              buf_wr.en = 1'b1;
              len_nxt   = len_e + LEN_W'(1);
              mask_nxt  = keep;
              if (hit) begin
                phase_nxt = PH_DROP;
              end else if (keep == '0) begin
                do_flush  = 1'b1;
                flush_len = len_e + LEN_W'(1);
                phase_nxt = PH_PASS;
                first_nxt = 1'b0;
              end
            end
          end
        endcase
      end
    end

    cmd.has_sep   = do_flush && !first_r;
    cmd.flush_len = do_flush ? flush_len : '0;
    cmd.has_tail  = has_tail;
    cmd.tail_char = tail_char;
    cmd_push      = do_flush || has_tail;

    if (accept && do_flush) begin
      pend_nxt = 1'b1;
    end else if (flush_done) begin
      pend_nxt = 1'b0;
    end else begin
      pend_nxt = pend_r;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      mask_r  <= ALL_PATTERNS;
      phase_r <= PH_BETWEEN;
      first_r <= 1'b1;
      pend_r  <= 1'b0;
    end else begin
      len_r   <= len_nxt;
      mask_r  <= mask_nxt;
      phase_r <= phase_nxt;
      first_r <= first_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tpbf_cmd_fifo.sv
// ----------------------------------------------------------------------------
// tpbf_cmd_fifo: command queue between classifier and emitter
// Small register FIFO of output commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tpbf_cmd_fifo #(
  parameter int DEPTH = tpbf_pkg::CMD_FIFO_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tpbf_pkg::cmd_t push_data,
  output      logic          full,
  input  wire logic          pop,
  output      tpbf_pkg::cmd_t pop_data,
  output      logic          empty
);
  import tpbf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             store [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = store[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tpbf_back.sv
// ----------------------------------------------------------------------------
// tpbf_back: output emitter
// Expands each command into separator, buffered token bytes and tail byte,
// driving a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tpbf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_empty,
  input  wire tpbf_pkg::cmd_t  cmd_data,
  output      logic           cmd_pop,
  output      logic           rd_en,
  output      tpbf_pkg::idx_t  rd_addr,
  input  wire logic [7:0]     rd_data,
  output      logic           flush_done,
  output      logic           buf_busy,
  output      logic           out_valid,
  input  wire logic           out_stall,
  output      logic [7:0]     out_char,
  output      logic           out_last
);
  import tpbf_pkg::*;

  back_state_t state_r, state_nxt;
  cmd_t        cmd_r,   cmd_nxt;
  idx_t        idx_r,   idx_nxt;
  logic        out_valid_r;
  logic [7:0]  out_char_r;
  logic        out_last_r;

  logic        slot_free;
  logic        load;
  logic [7:0]  ld_char;
  logic        ld_last;
  logic        last_idx;

  assign slot_free = !out_valid_r || !out_stall;
  assign last_idx  = (LEN_W'(idx_r) + LEN_W'(1) == cmd_r.flush_len);
  assign buf_busy  = (state_r == BK_READ) || (state_r == BK_BUF);

  // run sequencer
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    cmd_pop    = 1'b0;
    load       = 1'b0;
    ld_char    = cmd_r.tail_char;
    ld_last    = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = idx_r;
    flush_done = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd_data;
          idx_nxt = '0;
          if (cmd_data.has_sep) begin
            state_nxt = BK_SEP;
          end else if (cmd_data.flush_len != '0) begin
            state_nxt = BK_READ;
          end else if (cmd_data.has_tail) begin
            state_nxt = BK_TAIL;
          end
        end
      end
      BK_SEP: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_char = CHAR_SPACE;
          ld_last = (cmd_r.flush_len == '0) && !cmd_r.has_tail;
          if (cmd_r.flush_len != '0) begin
            state_nxt = BK_READ;
          end else if (cmd_r.has_tail) begin
            state_nxt = BK_TAIL;
          end else begin
            state_nxt = BK_IDLE;
          end
        end
      end
      BK_READ: begin
        rd_en     = 1'b1;
        state_nxt = BK_BUF;
      end
      BK_BUF: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_char = rd_data;
          ld_last = last_idx && !cmd_r.has_tail;
          if (last_idx) begin
            flush_done = 1'b1;
            state_nxt  = cmd_r.has_tail ? BK_TAIL : BK_IDLE;
          end else begin
            // prefetch next buffered byte
            idx_nxt = idx_r + IDX_W'(1);
            rd_en   = 1'b1;
            rd_addr = idx_r + IDX_W'(1);
          end
        end
      end
      BK_TAIL: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_last   = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r <= ld_char;
      out_last_r <= ld_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

FILE: hw/rtl/token_prefix_blacklist_filter_top.sv
// ----------------------------------------------------------------------------
// token_prefix_blacklist_filter_top: drops tokens starting with fixed prefixes
// Input channel (in_valid/in_stall): one line byte per transaction, or an
// end-of-line marker. Result channel (out_valid/out_stall): filtered bytes,
// out_last_of_run set on the final byte a transaction produces.
// Register filter_enable at address 0 (APB write, reset 1); 0 passes bytes.
// In the emitter a pass-through byte goes through the idle and tail states. A
// token release emits the separator, reads the buffer RAM and then streams
// 1 byte per cycle while the result channel is not stalled; input is held
// off until the buffered bytes have been read out of the RAM. A 4-entry
// command queue decouples classifier and emitter, so input keeps flowing
// while results wait.
// Reset: line state cleared, no pending results, filter enabled.
// A stalled result holds its byte; the emitter then stops, the queue fills,
// and in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module token_prefix_blacklist_filter_top #(
  parameter int CMD_DEPTH = tpbf_pkg::CMD_FIFO_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire logic [7:0]                      in_char_in,
  input  wire logic                            in_end_of_line,
  // result channel
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      logic [7:0]                      out_char_out,
  output      logic                            out_last_of_run,
  // configuration
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [tpbf_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [tpbf_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output      logic [tpbf_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output      logic                            cfg_pready
);
  import tpbf_pkg::*;

  logic    enable_r;
  logic    cfg_wr;
  logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t    cmd_in, cmd_out;
  buf_wr_t buf_wr;
  logic    rd_en;
  idx_t    rd_addr;
  logic [7:0] rd_data;
  logic    flush_done, flush_pend, buf_busy;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
    end else if (cfg_wr && (cfg_paddr[2] == REG_FILTER_ENABLE)) begin
      enable_r <= cfg_pwdata[0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_FILTER_ENABLE) begin
      cfg_prdata[0] = enable_r;
    end
  end

  tpbf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .filter_enable (enable_r),
    .in_valid      (in_valid),
    .in_char       (in_char_in),
    .in_eol        (in_end_of_line),
    .in_stall      (in_stall),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in),
    .cmd_full      (cmd_full),
    .flush_done    (flush_done),
    .buf_wr        (buf_wr),
    .flush_pend    (flush_pend)
  );

  tpbf_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  tpbf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PATTERN_LEN)
  ) u_token_buf (
    .clk   (clk),
    .we    (buf_wr.en),
    .waddr (buf_wr.addr),
    .wdata (buf_wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  tpbf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_empty  (cmd_empty),
    .cmd_data   (cmd_out),
    .cmd_pop    (cmd_pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .flush_done (flush_done),
    .buf_busy   (buf_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char_out),
    .out_last   (out_last_of_run)
  );

  // a command is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_push && cmd_full))
    else $error("command pushed into full queue");

  // buffer reads only happen while the classifier holds off new input
  a_read_guarded: assert property (@(posedge clk) disable iff (!rst_n)
    buf_busy |-> flush_pend)
    else $error("token buffer read without pending flush");

  // buffer is never written while its contents are being released
  a_no_write_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    flush_pend |-> !buf_wr.en)
    else $error("token buffer written during flush");

endmodule

`default_nettype wire

FILE: test/tpbf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tpbf_checker: result predictor and scoreboard for the prefix filter
// Watches the input, result and register ports, keeps its own copy of the
// line state, works out the bytes each input transaction must produce and
// compares every result transaction against the oldest expected byte.
// ----------------------------------------------------------------------------
module tpbf_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [7:0]                      in_char_in,
  input  logic                            in_end_of_line,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [7:0]                      out_char_out,
  input  logic                            out_last_of_run,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic                            cfg_pready,
  input  logic [tpbf_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [tpbf_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output int                              fail_count,
  output int                              pending_count,
  output int                              items_seen,
  output int                              bytes_seen
);
  import tpbf_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] ADDR_FILTER_ENABLE = {REG_FILTER_ENABLE, 2'b00};
  localparam int MAX_PRINTED = 30;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_byte_t;

  // Blocked token prefixes
  string      blocked_prefix [PATTERN_COUNT];

  // Shadow line state
  logic       filt_en;
  phase_t     phase;
  logic [7:0] tok_buf [MAX_PATTERN_LEN];
  int         tok_len;
  mask_t      cand;
  logic       first_vis;

  out_byte_t  expected_bytes [$];
  out_byte_t  run_bytes [$];
  out_byte_t  want;

  initial begin
    fail_count = 0;
    items_seen = 0;
    bytes_seen = 0;
    pending_count = 0;
    blocked_prefix[0] = {"stack_depot", "_disable"};
    blocked_prefix[1] = {"cgroup", "_disable"};
    blocked_prefix[2] = {"loop.max", "_part"};
    blocked_prefix[3] = {"BOOT", "_IMAGE"};
    blocked_prefix[4] = {"syscall", "_hardening"};
    blocked_prefix[5] = {"button.lid", "_init_state"};
    blocked_prefix[6] = "ROOT=";
    blocked_prefix[7] = "SRC=";
    blocked_prefix[8] = {"android", "boot.bootctrl", "_bootcfg"};
  end

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  function automatic void clear_line();
    tok_len = 0;
    cand = ALL_PATTERNS;
    phase = PH_BETWEEN;
    first_vis = 1'b1;
  endfunction

  function automatic void put_byte(input logic [7:0] c);
    run_bytes.push_back('{c, 1'b0});
  endfunction

  // Release the held token, with a separator unless it leads the line
  function automatic void flush_held();
    if (!first_vis) put_byte(CHAR_SPACE);
    for (int k = 0; k < tok_len && k < MAX_PATTERN_LEN; k++) begin
      put_byte(tok_buf[k]);
    end
    first_vis = 1'b0;
  endfunction

  // One non-space byte with filtering on
  function automatic void classify_byte(input logic [7:0] c);
    int    pos;
    int    plen;
    mask_t keep;
    logic  hit;
    hit = 1'b0;
    if (phase == PH_BETWEEN) begin
      tok_len = 0;
      cand = ALL_PATTERNS;
      phase = PH_BUFFER;
    end
    if (phase == PH_PASS) begin
      put_byte(c);
      return;
    end
    if (phase == PH_DROP) return;
    pos = tok_len;
    // buffer overrun: release and stream on
    if (pos >= MAX_PATTERN_LEN) begin
      flush_held();
      phase = PH_PASS;
      put_byte(c);
      return;
    end
    keep = cand;
    for (int i = 0; i < PATTERN_COUNT; i++) begin
      if (keep[i]) begin
        plen = blocked_prefix[i].len();
        if (pos < plen && blocked_prefix[i][pos] == c) begin
          if (pos + 1 == plen) hit = 1'b1;
        end else begin
          keep[i] = 1'b0;
        end
      end
    end
    tok_buf[pos] = c;
    tok_len = pos + 1;
    cand = keep;
    if (hit) begin
      phase = PH_DROP;
    end else if (keep == '0) begin
      flush_held();
      phase = PH_PASS;
    end
  endfunction

  // Expected bytes of one input transaction, appended to the queue
  function automatic void predict_item(input logic [7:0] c, input logic eol);
    run_bytes.delete();
    if (eol) begin
      if (filt_en && phase == PH_BUFFER) flush_held();
      put_byte(CHAR_NEWLINE);
      clear_line();
    end else if (!filt_en) begin
      put_byte(c);
    end else if (c == CHAR_SPACE) begin
      if (phase == PH_BUFFER) flush_held();
      phase = PH_BETWEEN;
    end else begin
      classify_byte(c);
    end
    if (run_bytes.size() > 0) run_bytes[run_bytes.size() - 1].last = 1'b1;
    foreach (run_bytes[i]) expected_bytes.push_back(run_bytes[i]);
  endfunction

  // Monitor: register writes, input and result transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      filt_en = 1'b1;
      clear_line();
      expected_bytes.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == ADDR_FILTER_ENABLE) begin
        filt_en = cfg_pwdata[0];
      end
      if (in_valid && !in_stall) begin
        items_seen++;
        predict_item(in_char_in, in_end_of_line);
      end
      if (out_valid && !out_stall) begin
        bytes_seen++;
        if (expected_bytes.size() == 0) begin
          report($sformatf("unexpected result byte 0x%02h last %0b",
                           out_char_out, out_last_of_run));
        end else begin
          want = expected_bytes.pop_front();
          if (out_char_out !== want.ch) begin
            report($sformatf("result %0d: char 0x%02h, expected 0x%02h",
                             bytes_seen, out_char_out, want.ch));
          end
          if (out_last_of_run !== want.last) begin
            report($sformatf("result %0d: last_of_run %0b, expected %0b",
                             bytes_seen, out_last_of_run, want.last));
          end
        end
      end
    end
    pending_count <= expected_bytes.size();
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the token prefix blacklist filter
// Drives directed lines, then random lines built mostly from blocked
// prefixes, near misses and partial tokens, under several idle and stall
// mixes, with the filter on and off, and a long result hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import tpbf_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] ADDR_FILTER_ENABLE = {REG_FILTER_ENABLE, 2'b00};
  localparam int REG_SPARE = 1;                     // no register at this index
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE = CFG_ADDR_W'(4 * REG_SPARE);
  localparam int IDLE_SLACK  = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 30;

  typedef enum int {TK_FULL, TK_PARTIAL, TK_DIVERGE, TK_NEAR, TK_RANDOM} tok_kind_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_char_in = '0;
  logic                  in_end_of_line = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_char_out;
  logic                  out_last_of_run;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int fail_count;
  int pending_count;
  int items_seen;
  int bytes_seen;

  int   send_idle_pct = 0;
  int   stall_pct = 0;
  bit   holdoff_req = 1'b0;
  int   items_sent = 0;
  int   send_pcts [4] = '{0, 63, 0, 25};
  int   stall_pcts [4] = '{0, 0, 63, 25};

  string      prefix_text [PATTERN_COUNT];
  logic [7:0] line_q [$];

  token_prefix_blacklist_filter_top dut (.*);
  tpbf_checker chk (.*);

  always #5 clk = ~clk;

  // Result side: random stalls, or a long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
    end
  end

  // One input transaction, with random idle cycles in front
  task automatic send_item(input logic [7:0] c, input logic eol);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_in <= c;
    in_end_of_line <= eol;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_eol();
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  // Stop offering, let every expected byte arrive, then allow for drops
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (IDLE_SLACK) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CHAR_SPACE);
    return b;
  endfunction

  // Append one token: mostly blocked prefixes, their heads and near misses
  function automatic void add_token();
    tok_kind_t  kind;
    int         p;
    int         plen;
    int         n;
    int         tail;
    logic [7:0] b;
    kind = tok_kind_t'($urandom_range(4));
    p = $urandom_range(PATTERN_COUNT - 1);
    plen = prefix_text[p].len();
    tail = $urandom_range(3);
    case (kind)
      TK_FULL: n = plen;
      TK_PARTIAL: begin
        n = ($urandom_range(3) == 0) ? plen - 1 : $urandom_range(plen - 1, 1);
        tail = 0;
      end
      TK_DIVERGE: n = ($urandom_range(3) == 0) ? plen - 1 : $urandom_range(plen - 1);
      TK_NEAR: n = plen - 1;
      default: begin
        n = 0;
        tail = $urandom_range(6, 1);
      end
    endcase
    for (int k = 0; k < n; k++) line_q.push_back(prefix_text[p][k]);
    if (kind == TK_DIVERGE || kind == TK_NEAR) begin
      do b = plain_byte(); while (b == prefix_text[p][n]);
      line_q.push_back(b);
    end
    for (int k = 0; k < tail; k++) line_q.push_back(plain_byte());
  endfunction

  // A line of tokens, or now and then raw noise; closed by an end marker if close is set
  task automatic send_line(input bit close);
    int ntok;
    line_q.delete();
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(16, 1)) begin
        line_q.push_back(($urandom_range(3) == 0) ? CHAR_SPACE : 8'($urandom_range(255)));
      end
    end else begin
      if ($urandom_range(4) == 0) line_q.push_back(CHAR_SPACE);
      ntok = $urandom_range(4, 1);
      for (int k = 0; k < ntok; k++) begin
        if (k > 0) repeat ($urandom_range(2, 1)) line_q.push_back(CHAR_SPACE);
        add_token();
      end
      if ($urandom_range(4) == 0) line_q.push_back(CHAR_SPACE);
    end
    foreach (line_q[i]) send_item(line_q[i], 1'b0);
    if (close) send_eol();
  endtask

  // Whole lines up to the item target; may stop in mid-line
  task automatic run_phase(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) send_line(1'b1);
    if ($urandom_range(1)) send_line(1'b0);
  endtask

  // Run limit
  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    prefix_text[0] = {"stack_depot", "_disable"};
    prefix_text[1] = {"cgroup", "_disable"};
    prefix_text[2] = {"loop.max", "_part"};
    prefix_text[3] = {"BOOT", "_IMAGE"};
    prefix_text[4] = {"syscall", "_hardening"};
    prefix_text[5] = {"button.lid", "_init_state"};
    prefix_text[6] = "ROOT=";
    prefix_text[7] = "SRC=";
    prefix_text[8] = {"android", "boot.bootctrl", "_bootcfg"};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty line, dropped token, token cut short while held
    send_eol();
    send_text("ROOT=");
    send_item(CHAR_SPACE, 1'b0);
    send_text("SRC");
    send_eol();
    // zero and all-ones bytes, repeated spaces, held token released by a miss
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CHAR_SPACE, 1'b0);
    send_item(CHAR_SPACE, 1'b0);
    send_text("B");
    send_item(8'hFF, 1'b0);
    send_eol();
    // filter switched off and back on in mid-token; spare index ignored
    send_text("ROO");
    wait_idle();
    cfg_write(ADDR_FILTER_ENABLE, 32'hFFFF_FFFE);
    send_item(CHAR_SPACE, 1'b0);
    wait_idle();
    cfg_write(ADDR_SPARE, 32'h0000_0001);
    send_text("c");
    wait_idle();
    cfg_write(ADDR_FILTER_ENABLE, 32'h0000_0001);
    send_text("T=");
    send_eol();

    // Random lines under each idle/stall mix
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      send_idle_pct = send_pcts[ph];
      stall_pct = stall_pcts[ph];
      run_phase(PHASE_ITEMS);
    end

    // Filter off, then back on, possibly in mid-line
    wait_idle();
    cfg_write(ADDR_FILTER_ENABLE, 32'h0000_0000);
    run_phase(20);
    wait_idle();
    cfg_write(ADDR_FILTER_ENABLE, 32'h0000_0001);

    // Long result hold-off while input keeps coming; includes a full burst
    send_idle_pct = 0;
    stall_pct = 0;
    holdoff_req = 1'b1;
    send_line(1'b0);
    send_item(CHAR_SPACE, 1'b0);
    send_text("x");
    send_item(CHAR_SPACE, 1'b0);
    send_text(prefix_text[8].substr(0, MAX_PATTERN_LEN - 2));
    send_item(8'h58, 1'b0);
    send_eol();
    run_phase(10);
    send_eol();
    wait_idle();

    $display("covered %0d input transactions and %0d result bytes, filter on and off",
             items_seen, bytes_seen);
    $display("mixes: free flow, input gaps, result stalls, both, long result hold-off");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
